>>> rtl/core/priority_task_scheduler_assert.svh
// Assertion macros shared by the scheduler checker.
`ifndef PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_ASSERT_SVH

// Clocked assertion, off while reset is held.
`define PTS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also runs during reset.
`define PTS_ASSERT_NR(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> rtl/core/ptsch_pkg.sv
// Types, constants and helpers for the priority task scheduler.
`default_nettype none
package ptsch_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int TOTAL_W    = $clog2(TASK_SLOTS + 1);

    localparam int OP_W     = 3;
    localparam int FUNC_W   = 8;
    localparam int PRIO_W   = 3;
    localparam int TICK_W   = 32;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 3;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;

    typedef enum logic [1:0] {
        ST_READY     = 2'd0,
        ST_RUNNING   = 2'd1,
        ST_SLEEPING  = 2'd2,
        ST_SUSPENDED = 2'd3
    } task_state_t;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_DISPATCH = 3'd1,
        OP_ADD      = 3'd2,
        OP_SUSPEND  = 3'd3,
        OP_RESUME   = 3'd4,
        OP_SLEEP    = 3'd5,
        OP_FINISH   = 3'd6
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_FULL       = 3'd1,
        STAT_NO_MATCH   = 3'd2,
        STAT_NONE_READY = 3'd3,
        STAT_NO_CURRENT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_MARK,
        FSM_RESP
    } fsm_t;

    typedef struct packed {
        task_state_t         state;
        logic [PRIO_W-1:0]   prio;
        logic [FUNC_W-1:0]   func;
        logic [TICK_W-1:0]   sleep_left;
        logic [TICK_W-1:0]   last_start;
    } entry_t;

    // Low bits of a slot number as reported on the result word.
    function automatic logic [IDX_W-1:0] to_index(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W+IDX_W-1:0] wide;
        wide = (SLOT_W + IDX_W)'(slot);
        return wide[IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/ptsch_cell.sv
// One task slot of the rotating task table.
`default_nettype none
module ptsch_cell (
    input  wire logic             aclk,
    input  wire logic             shift_en,
    input  ptsch_pkg::entry_t     entry_in,
    output ptsch_pkg::entry_t     entry_out
);
    import ptsch_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = shift_en ? entry_in : entry_reg;
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;

endmodule
`default_nettype wire

>>> rtl/core/ptsch_ctrl.sv
// Sequencer, head-of-ring update logic and result register of the scheduler.
`default_nettype none
module ptsch_ctrl (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ptsch_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ptsch_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                 shift_en,
    input  ptsch_pkg::entry_t                    head_q,
    output ptsch_pkg::entry_t                    tail_d
);
    import ptsch_pkg::*;

    fsm_t                fsm_reg, fsm_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    opcode_t             op_reg;
    logic [FUNC_W-1:0]   fid_reg;
    logic [PRIO_W-1:0]   prio_reg;
    logic [TICK_W-1:0]   ticks_reg;
    logic                found_reg, found_next;
    logic [SLOT_W-1:0]   pick_reg, pick_next;
    logic [PRIO_W-1:0]   best_reg, best_next;
    logic [TICK_W-1:0]   tick_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic                cur_valid_reg;
    logic [SLOT_W-1:0]   cur_slot_reg;
    status_t             res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic accept;
    logic last_pos;
    logic in_tbl;
    logic at_cur;
    logic full;
    logic out_free;

    assign accept   = s_tvalid && s_tready;
    assign last_pos = (pos_reg == SLOT_W'(TASK_SLOTS - 1));
    assign in_tbl   = (TOTAL_W'(pos_reg) < total_reg);
    assign at_cur   = cur_valid_reg && (pos_reg == cur_slot_reg);
    assign full     = (total_reg == TOTAL_W'(TASK_SLOTS));
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state.
    always_comb begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            FSM_IDLE: begin
                if (s_tvalid) fsm_next = FSM_SCAN;
            end
            FSM_SCAN: begin
                if (last_pos) begin
                    fsm_next = (op_reg == OP_DISPATCH && found_next) ? FSM_MARK : FSM_RESP;
                end
            end
            FSM_MARK: begin
                if (last_pos) fsm_next = FSM_RESP;
            end
            FSM_RESP: begin
                if (out_free) fsm_next = FSM_IDLE;
            end
            default: fsm_next = FSM_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready = (fsm_reg == FSM_IDLE);
        shift_en = (fsm_reg == FSM_SCAN) || (fsm_reg == FSM_MARK);
    end

    // Update the slot at the head of the ring and feed it back to the tail.
    always_comb begin
        task_state_t st;
        st         = head_q.state;
        tail_d     = head_q;
        found_next = found_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        if (fsm_reg == FSM_SCAN) begin
            unique case (op_reg)
                OP_TICK: begin
                    if (in_tbl && head_q.state == ST_SLEEPING) begin
                        if (head_q.sleep_left != '0) begin
                            tail_d.sleep_left = head_q.sleep_left - TICK_W'(1);
                        end
                        if (head_q.sleep_left <= TICK_W'(1)) tail_d.state = ST_READY;
                    end
                end
                OP_DISPATCH: begin
                    if (in_tbl) begin
                        // retire the current task before choosing
                        if (at_cur && st == ST_RUNNING) st = ST_READY;
                        tail_d.state = st;
                        if (st == ST_READY && head_q.prio > best_reg) begin
                            best_next  = head_q.prio;
                            pick_next  = pos_reg;
                            found_next = 1'b1;
                        end
                    end
                end
                OP_ADD: begin
                    if (!full && TOTAL_W'(pos_reg) == total_reg) begin
                        tail_d.state      = ST_READY;
                        tail_d.prio       = prio_reg;
                        tail_d.func       = fid_reg;
                        tail_d.sleep_left = '0;
                        tail_d.last_start = '0;
                    end
                end
                OP_SUSPEND, OP_RESUME: begin
                    if (in_tbl && !found_reg && head_q.func == fid_reg) begin
                        tail_d.state = (op_reg == OP_SUSPEND) ? ST_SUSPENDED : ST_READY;
                        found_next   = 1'b1;
                        pick_next    = pos_reg;
                    end
                end
                OP_SLEEP: begin
                    if (at_cur) begin
                        tail_d.state      = ST_SLEEPING;
                        tail_d.sleep_left = ticks_reg;
                    end
                end
                OP_FINISH: begin
                    if (at_cur && head_q.state == ST_RUNNING) tail_d.state = ST_READY;
                end
                default: begin
                end
            endcase
        end else if (fsm_reg == FSM_MARK && pos_reg == pick_reg) begin
            tail_d.state      = ST_RUNNING;
            tail_d.last_start = tick_reg;
        end
    end

    // Result of the item, taken at the end of the scan pass.
    always_comb begin
        res_status_next = STAT_OK;
        res_idx_next    = '0;
        unique case (op_reg)
            OP_DISPATCH: begin
                if (found_next) res_idx_next = to_index(pick_next);
                else            res_status_next = STAT_NONE_READY;
            end
            OP_ADD: begin
                if (full) res_status_next = STAT_FULL;
                else      res_idx_next    = to_index(SLOT_W'(total_reg));
            end
            OP_SUSPEND, OP_RESUME: begin
                if (found_next) res_idx_next = to_index(pick_next);
                else            res_status_next = STAT_NO_MATCH;
            end
            OP_SLEEP, OP_FINISH: begin
                if (cur_valid_reg) res_idx_next = to_index(cur_slot_reg);
                else               res_status_next = STAT_NO_CURRENT;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        pos_next = pos_reg;
        if (accept) pos_next = '0;
        else if (shift_en) pos_next = last_pos ? '0 : pos_reg + SLOT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg       <= FSM_IDLE;
            tick_reg      <= '0;
            total_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_slot_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            fsm_reg <= fsm_next;
            if (accept && s_tdata[2:0] == OP_TICK) tick_reg <= tick_reg + TICK_W'(1);
            if (fsm_reg == FSM_SCAN && last_pos) begin
                unique case (op_reg)
                    OP_DISPATCH: begin
                        cur_valid_reg <= found_next;
                        if (found_next) cur_slot_reg <= pick_next;
                    end
                    OP_ADD: begin
                        if (!full) total_reg <= total_reg + TOTAL_W'(1);
                    end
                    OP_FINISH: begin
                        cur_valid_reg <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (fsm_reg == FSM_RESP && out_free) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        if (accept) begin
            op_reg    <= opcode_t'(s_tdata[2:0]);
            fid_reg   <= s_tdata[10:3];
            prio_reg  <= s_tdata[13:11];
            ticks_reg <= s_tdata[45:14];
            found_reg <= 1'b0;
            pick_reg  <= '0;
            best_reg  <= '0;
        end else if (fsm_reg == FSM_SCAN) begin
            found_reg <= found_next;
            pick_reg  <= pick_next;
            best_reg  <= best_next;
        end
        if (fsm_reg == FSM_SCAN && last_pos) begin
            res_status_reg <= res_status_next;
            res_idx_reg    <= res_idx_next;
        end
        if (fsm_reg == FSM_RESP && out_free) begin
            m_data_reg <= {2'b00, tick_reg, res_idx_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

>>> rtl/core/priority_task_scheduler.sv
// Top level of the fixed-priority task scheduler: ring of slot cells plus controller.
// Use:
//   Slave channel s_*: one command word per task-kernel event (tick, dispatch,
//   add, suspend, resume, sleep, finish). Master channel m_*: exactly one
//   result word per command, in command order.
//   The task table is a ring of TASK_SLOTS cells that rotates one slot per cycle,
//   while a scan or mark pass runs, past the update logic at its head. A dispatch
//   that picks a task takes a second pass to mark it running. s_tready is high only
//   while no command is in work. A finished result waits in the output register;
//   the next command is taken meanwhile, and its own result waits in the controller
//   until the register frees.
//   Reset (aresetn low, synchronous): table empty, tick count zero, no current
//   task, no result pending. No clearing pass is needed.
`default_nettype none
module priority_task_scheduler (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // opcode[2:0], func_id[10:3], priority_req[13:11], sleep_ticks[45:14], zero[47:46]
    input  wire logic [ptsch_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // status[2:0], task_index[5:3], tick_now[37:6], zero[39:38]
    output logic [ptsch_pkg::M_DATA_W-1:0]       m_tdata
);
    import ptsch_pkg::*;

    logic   shift_en;
    entry_t cell_q [TASK_SLOTS];
    entry_t cell_d [TASK_SLOTS];
    entry_t tail_d;

    for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_ring
        if (i == TASK_SLOTS - 1) begin : g_tail
            assign cell_d[i] = tail_d;
        end else begin : g_mid
            assign cell_d[i] = cell_q[i+1];
        end
        ptsch_cell u_cell (
            .aclk      (aclk),
            .shift_en  (shift_en),
            .entry_in  (cell_d[i]),
            .entry_out (cell_q[i])
        );
    end

    ptsch_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .shift_en (shift_en),
        .head_q   (cell_q[0]),
        .tail_d   (tail_d)
    );

endmodule
`default_nettype wire

>>> rtl/core/ptsch_checker.sv
// Port-level checker for the priority task scheduler, bound to the top level.
`default_nettype none
`include "priority_task_scheduler_assert.svh"
module ptsch_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [ptsch_pkg::S_DATA_W-1:0]  s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [ptsch_pkg::M_DATA_W-1:0]  m_tdata
);
    import ptsch_pkg::*;

    logic unused_in;
    assign unused_in = ^s_tdata;

    // one command in work at a time
    `PTS_ASSERT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "command accepted while busy")

    `PTS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    `PTS_ASSERT(a_status_range, aclk, aresetn, m_tvalid |-> m_tdata[2:0] <= STAT_NO_CURRENT, "status code out of range")

    // failed commands report slot zero
    `PTS_ASSERT(a_err_index, aclk, aresetn, m_tvalid && m_tdata[2:0] != STAT_OK |-> m_tdata[5:3] == 3'd0, "index set on failed command")

    `PTS_ASSERT_NR(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind priority_task_scheduler ptsch_checker u_ptsch_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
